/* src/fgc_pkg.sv */
//------------------------------------------------------------------------------
// fgc_pkg
// Types, weights and sigmoid table of the force gesture classifier.
//------------------------------------------------------------------------------
`default_nettype none
package fgc_pkg;
   localparam int FieldCh  = 5;
   localparam int WinLen   = 6;
   localparam int HidNodes = 4;
   localparam int ClassCnt = 3;

   typedef logic [15:0] force_type;
   typedef logic [16:0] diff_type;

   typedef enum logic [1:0] {
      GEST_NONE   = 2'd0,
      GEST_DOWN   = 2'd1,
      GEST_ROTATE = 2'd2,
      GEST_UP     = 2'd3
   } gesture_type;

   // input weight, Q2.14, [window tap][hidden node]
   function automatic logic signed [15:0] w_in(input logic [2:0] i, input logic [1:0] j);
      logic signed [15:0] r;
      r = '0;
      case ({i, j})
         5'd0:  r = 16'sd12408;  5'd1:  r = -16'sd6561;  5'd2:  r = -16'sd1484;
         5'd3:  r = -16'sd10099;
         5'd4:  r = 16'sd1689;   5'd5:  r = -16'sd2068;  5'd6:  r = -16'sd3138;
         5'd7:  r = -16'sd5588;
         5'd8:  r = 16'sd7419;   5'd9:  r = -16'sd643;   5'd10: r = -16'sd2043;
         5'd11: r = 16'sd110;
         5'd12: r = 16'sd21228;  5'd13: r = -16'sd5512;  5'd14: r = -16'sd11514;
         5'd15: r = -16'sd7218;
         5'd16: r = 16'sd17922;  5'd17: r = -16'sd8046;  5'd18: r = -16'sd567;
         5'd19: r = -16'sd6168;
         5'd20: r = 16'sd13592;  5'd21: r = -16'sd6950;  5'd22: r = -16'sd510;
         5'd23: r = -16'sd4235;
         default: r = '0;
      endcase
      return r;
   endfunction

   // hidden weight, Q6.10, [hidden node][class]
   function automatic logic signed [15:0] w_hid(input logic [1:0] j, input logic [1:0] k);
      logic signed [15:0] r;
      r = '0;
      case ({j, k})
         4'd0:  r = 16'sd12021;  4'd1:  r = 16'sd4938;   4'd2:  r = -16'sd17799;
         4'd4:  r = 16'sd18474;  4'd5:  r = -16'sd28674; 4'd6:  r = 16'sd3722;
         4'd8:  r = -16'sd9818;  4'd9:  r = 16'sd1532;   4'd10: r = 16'sd22303;
         4'd12: r = -16'sd18106; 4'd13: r = 16'sd31813;  4'd14: r = -16'sd14282;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic signed [15:0] bias_hid(input logic [1:0] j);
      logic signed [15:0] r;
      case (j)
         2'd0: r = 16'sd9467;
         2'd1: r = -16'sd878;
         2'd2: r = 16'sd4909;
         default: r = 16'sd2159;
      endcase
      return r;
   endfunction

   function automatic logic signed [15:0] bias_out(input logic [1:0] k);
      logic signed [15:0] r;
      case (k)
         2'd0: r = -16'sd3289;
         2'd1: r = -16'sd9393;
         default: r = -16'sd2389;
      endcase
      return r;
   endfunction

   function automatic logic [16:0] sig_tab(input logic [4:0] i);
      logic [16:0] r;
      case (i)
         5'd0:  r = 17'd32768; 5'd1:  r = 17'd40793; 5'd2:  r = 17'd47911;
         5'd3:  r = 17'd53581; 5'd4:  r = 17'd57724; 5'd5:  r = 17'd60565;
         5'd6:  r = 17'd62428; 5'd7:  r = 17'd63615; 5'd8:  r = 17'd64357;
         5'd9:  r = 17'd64816; 5'd10: r = 17'd65097; 5'd11: r = 17'd65269;
         5'd12: r = 17'd65374; 5'd13: r = 17'd65438; 5'd14: r = 17'd65476;
         5'd15: r = 17'd65500;
         default: r = 17'd65514;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

/* src/force_gesture_mlp_classifier.sv */
//------------------------------------------------------------------------------
// force_gesture_mlp_classifier
// Five-channel force tracker with a 6-4-3 sigmoid perceptron classifier.
//------------------------------------------------------------------------------
// One word in, one word out per tick. A quiet tick goes straight to the
// response without touching the windows. An active tick shifts all windows in
// one memory pass, scans the channels in order, and runs the perceptron once
// per channel due for classification; each run uses the one perceptron unit
// (per hidden node 6 window products through the memory read and the product
// register, then the sigmoid steps; 12 output products, one compare, one
// handoff). Difference windows live in one synchronous memory, one word per
// channel and tap; reset is followed by a clearing pass over all 40 words
// before the first word is taken.
//------------------------------------------------------------------------------
`default_nettype none
module force_gesture_mlp_classifier #(
   parameter int CHANNELS = 5
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_force_ch0,
   input  wire logic [15:0] req_force_ch1,
   input  wire logic [15:0] req_force_ch2,
   input  wire logic [15:0] req_force_ch3,
   input  wire logic [15:0] req_force_ch4,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_point_valid,
   output logic [2:0]       rsp_point_index,
   output logic             rsp_gesture_valid,
   output logic [1:0]       rsp_gesture,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import fgc_pkg::*;

   localparam int UsedCh = (CHANNELS < FieldCh) ? CHANNELS : FieldCh;
   localparam int ChW    = 3;
   localparam int Depth  = 8 * FieldCh;
   localparam int AddrW  = $clog2(Depth);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SHIFT, S_SCAN, S_RUN, S_WAIT, S_OUT
   } state_type;

   // window memory, address {channel, tap}
   diff_type          mem [Depth];
   diff_type          rd_ff;
   logic [AddrW-1:0]  rd_addr;
   logic              wr_en;
   logic [AddrW-1:0]  wr_addr;
   diff_type          wr_data;

   state_type         state_ff;
   logic [15:0]       thr_ff [FieldCh];
   force_type         prev_ff [FieldCh];
   force_type         f_ff [FieldCh];
   logic [FieldCh-1:0] act_ff;
   logic [FieldCh-1:0] phase_ff;
   logic [AddrW-1:0]  clr_ff;
   logic [ChW-1:0]    ch_ff;       // shift: read channel
   logic [2:0]        tp_ff;       // shift: read tap
   logic              sh_v_ff;     // shift read in flight
   logic [ChW-1:0]    sh_ch_ff;
   logic [2:0]        sh_tp_ff;
   logic              class_ff;
   gesture_type       gest_ff;
   logic              pv_ff;
   logic [2:0]        pi_ff;
   logic              mlp_start;
   logic [2:0]        mlp_tap;
   logic              mlp_done;
   gesture_type       mlp_res;

   force_type         fin [FieldCh];
   logic [FieldCh-1:0] act_now;
   logic [2:0]        pi_now;

   assign fin[0] = req_force_ch0;
   assign fin[1] = req_force_ch1;
   assign fin[2] = req_force_ch2;
   assign fin[3] = req_force_ch3;
   assign fin[4] = req_force_ch4;

   always_comb begin
      pi_now = '0;
      for (int c = 0; c < FieldCh; c++) begin
         act_now[c] = (c < UsedCh) && (fin[c] > thr_ff[c]);
         if (act_now[c])
            pi_now = 3'(c);
      end
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = (state_ff == S_OUT);
   assign rsp_point_valid   = pv_ff;
   assign rsp_point_index   = pi_ff;
   assign rsp_gesture_valid = class_ff;
   assign rsp_gesture       = gest_ff;
   assign mlp_start         = (state_ff == S_SCAN) && act_ff[ch_ff] && phase_ff[ch_ff];

   // memory port muxing; shift reads tap t+1 and writes it to tap t
   always_comb begin
      rd_addr = AddrW'({ch_ff, mlp_tap});
      wr_en   = 1'b0;
      wr_addr = AddrW'({sh_ch_ff, sh_tp_ff - 3'd1});
      wr_data = rd_ff;
      if (state_ff == S_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else begin
         if (state_ff == S_SHIFT)
            rd_addr = AddrW'({ch_ff, tp_ff});
         // the last write of the pass lands in the first scan cycle
         if (sh_v_ff) begin
            wr_en = 1'b1;
            if (sh_tp_ff == 3'(WinLen)) begin
               wr_addr = AddrW'({sh_ch_ff, 3'(WinLen - 1)});
               wr_data = 17'({1'b0, f_ff[sh_ch_ff]} - {1'b0, prev_ff[sh_ch_ff]});
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   fgc_mlp u_mlp (
      .clock    (clock),
      .reset    (reset),
      .start    (mlp_start),
      .tap_addr (mlp_tap),
      .tap_data (rd_ff),
      .done     (mlp_done),
      .result   (mlp_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         thr_ff[0] <= 16'd8;
         thr_ff[1] <= 16'd32;
         thr_ff[2] <= 16'd48;
         thr_ff[3] <= 16'd80;
         thr_ff[4] <= 16'd80;
         for (int c = 0; c < FieldCh; c++)
            prev_ff[c] <= '0;
         phase_ff <= '0;
         gest_ff  <= GEST_NONE;
         sh_v_ff  <= 1'b0;
      end else begin
         if (csr_write && csr_index < 3'(FieldCh))
            thr_ff[csr_index] <= csr_data;
         sh_v_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == AddrW'(Depth - 1))
                  state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_valid) begin
                  for (int c = 0; c < FieldCh; c++)
                     f_ff[c] <= fin[c];
                  act_ff   <= act_now;
                  class_ff <= 1'b0;
                  pv_ff    <= |act_now;
                  pi_ff    <= pi_now;
                  ch_ff <= '0;
                  tp_ff <= 3'd1;
                  state_ff <= (|act_now) ? S_SHIFT : S_OUT;
               end
            end
            S_SHIFT: begin
               sh_v_ff  <= 1'b1;
               sh_ch_ff <= ch_ff;
               sh_tp_ff <= tp_ff;
               if (tp_ff == 3'(WinLen)) begin
                  tp_ff <= 3'd1;
                  if (ch_ff == ChW'(UsedCh - 1)) begin
                     ch_ff    <= '0;
                     state_ff <= S_SCAN;
                  end else
                     ch_ff <= ch_ff + 1'b1;
               end else
                  tp_ff <= tp_ff + 3'd1;
               if (sh_v_ff && sh_tp_ff == 3'(WinLen))
                  prev_ff[sh_ch_ff] <= f_ff[sh_ch_ff];
            end
            S_SCAN: begin
               if (sh_v_ff && sh_tp_ff == 3'(WinLen))
                  prev_ff[sh_ch_ff] <= f_ff[sh_ch_ff];
               if (act_ff[ch_ff]) begin
                  phase_ff[ch_ff] <= ~phase_ff[ch_ff];
                  if (phase_ff[ch_ff]) begin
                     state_ff <= S_WAIT;
                  end
               end
               if (!(act_ff[ch_ff] && phase_ff[ch_ff])) begin
                  if (ch_ff == ChW'(UsedCh - 1))
                     state_ff <= S_OUT;
                  else
                     ch_ff <= ch_ff + 1'b1;
               end
            end
            S_WAIT: begin
               if (mlp_done) begin
                  gest_ff  <= mlp_res;
                  class_ff <= 1'b1;
                  if (ch_ff == ChW'(UsedCh - 1))
                     state_ff <= S_OUT;
                  else begin
                     ch_ff    <= ch_ff + 1'b1;
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_OUT: begin
               if (rsp_ready)
                  state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

/* src/fgc_mlp.sv */
//------------------------------------------------------------------------------
// fgc_mlp
// Shared multiply-accumulate perceptron: 6-4-3 with tabled sigmoid.
//------------------------------------------------------------------------------
`default_nettype none
module fgc_mlp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic [2:0]               tap_addr,
   input  wire fgc_pkg::diff_type   tap_data,
   output logic                     done,
   output fgc_pkg::gesture_type     result
);
   import fgc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_HMAC, S_SIG, S_OMAC, S_CMP
   } state_type;

   state_type            state_ff, state_in;
   logic [2:0]           tap_ff, tap_in;     // window tap, counted ahead of data
   logic [1:0]           node_ff, node_in;
   logic [1:0]           cls_ff, cls_in;
   logic                 dvalid_ff, dvalid_in;
   logic [2:0]           dtap_ff, dtap_in;
   logic signed [39:0]   acc_ff, acc_in;
   logic signed [33:0]   prod_ff, prod_in;
   logic                 pvalid_ff, pvalid_in;
   logic [16:0]          h_ff [HidNodes];
   logic [16:0]          h_in;
   logic signed [47:0]   s_ff [ClassCnt];
   logic signed [47:0]   oacc_ff, oacc_in;
   logic [1:0]           ohid_ff, ohid_in;
   logic                 done_ff, done_in;
   gesture_type          res_ff, res_in;
   logic [2:0]           sg_step_ff, sg_step_in;
   logic [17:0]          sg_a_ff, sg_a_in;
   logic                 sg_neg_ff, sg_neg_in;
   logic [29:0]          sg_m_ff, sg_m_in;
   logic [16:0]          sg_base_ff, sg_base_in;

   assign tap_addr = tap_ff;
   assign done     = done_ff;
   assign result   = res_ff;

   logic signed [39:0] z_abs_src;
   logic signed [47:0] osum;
   logic [16:0] t_lo, t_hi;

   always_comb begin
      state_in   = state_ff;
      tap_in     = tap_ff;
      node_in    = node_ff;
      cls_in     = cls_ff;
      dvalid_in  = 1'b0;
      dtap_in    = tap_ff;
      acc_in     = acc_ff;
      prod_in    = prod_ff;
      pvalid_in  = 1'b0;
      oacc_in    = oacc_ff;
      ohid_in    = ohid_ff;
      done_in    = 1'b0;
      res_in     = res_ff;
      sg_step_in = sg_step_ff;
      sg_a_in    = sg_a_ff;
      sg_neg_in  = sg_neg_ff;
      sg_m_in    = sg_m_ff;
      sg_base_in = sg_base_ff;
      h_in       = '0;
      z_abs_src  = '0;
      osum       = '0;
      t_lo       = sig_tab(sg_a_ff[17:13]);
      t_hi       = sig_tab(sg_a_ff[17:13] + 5'd1);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_HMAC;
               node_in  = '0;
               tap_in   = '0;
               acc_in   = 40'(bias_hid(2'd0)) <<< 4;
            end
         end
         S_HMAC: begin
            // tap address issued, data next cycle, product the cycle after
            if (tap_ff != 3'(WinLen)) begin
               dvalid_in = 1'b1;
               dtap_in   = tap_ff;
               tap_in    = tap_ff + 3'd1;
            end
            if (dvalid_ff) begin
               prod_in   = 34'(w_in(dtap_ff, node_ff) * $signed(tap_data));
               pvalid_in = 1'b1;
            end
            if (pvalid_ff)
               acc_in = acc_ff + 40'(prod_ff);
            if (tap_ff == 3'(WinLen) && !dvalid_ff && !pvalid_ff) begin
               state_in   = S_SIG;
               sg_step_in = '0;
            end
         end
         S_SIG: begin
            case (sg_step_ff)
               3'd0: begin
                  sg_neg_in = acc_ff[39];
                  z_abs_src = acc_ff[39] ? -acc_ff : acc_ff;
                  sg_a_in   = (z_abs_src > 40'sd131072) ? 18'd131072 : z_abs_src[17:0];
                  sg_step_in = 3'd1;
               end
               3'd1: begin
                  sg_base_in = t_lo;
                  sg_m_in    = sg_a_ff[17] ? '0
                               : 30'((t_hi - t_lo) * sg_a_ff[12:0]);
                  sg_step_in = 3'd2;
               end
               default: begin
                  h_in = sg_base_ff + 17'(sg_m_ff >> 13);
                  if (sg_neg_ff)
                     h_in = 17'd65536 - h_in;
                  if (node_ff == 2'(HidNodes - 1)) begin
                     state_in = S_OMAC;
                     cls_in   = '0;
                     ohid_in  = '0;
                     oacc_in  = 48'(bias_out(2'd0)) <<< 16;
                  end else begin
                     node_in  = node_ff + 2'd1;
                     tap_in   = '0;
                     acc_in   = 40'(bias_hid(node_ff + 2'd1)) <<< 4;
                     state_in = S_HMAC;
                  end
               end
            endcase
         end
         S_OMAC: begin
            osum    = oacc_ff + 48'(w_hid(ohid_ff, cls_ff) * $signed({1'b0, h_ff[ohid_ff]}));
            oacc_in = osum;
            ohid_in = ohid_ff + 2'd1;
            if (ohid_ff == 2'(HidNodes - 1)) begin
               if (cls_ff == 2'(ClassCnt - 1))
                  state_in = S_CMP;
               else begin
                  cls_in  = cls_ff + 2'd1;
                  oacc_in = 48'(bias_out(cls_ff + 2'd1)) <<< 16;
               end
            end
         end
         S_CMP: begin
            if (s_ff[0] > s_ff[1] && s_ff[0] > s_ff[2])
               res_in = GEST_DOWN;
            else if (s_ff[2] > s_ff[1] && s_ff[2] > s_ff[0])
               res_in = GEST_UP;
            else if (s_ff[1] > s_ff[0] && s_ff[1] > s_ff[2])
               res_in = GEST_ROTATE;
            else
               res_in = GEST_NONE;
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         done_ff   <= 1'b0;
         dvalid_ff <= 1'b0;
         pvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         done_ff   <= done_in;
         dvalid_ff <= dvalid_in;
         pvalid_ff <= pvalid_in;
      end
      tap_ff     <= tap_in;
      node_ff    <= node_in;
      cls_ff     <= cls_in;
      dtap_ff    <= dtap_in;
      acc_ff     <= acc_in;
      prod_ff    <= prod_in;
      oacc_ff    <= oacc_in;
      ohid_ff    <= ohid_in;
      res_ff     <= res_in;
      sg_step_ff <= sg_step_in;
      sg_a_ff    <= sg_a_in;
      sg_neg_ff  <= sg_neg_in;
      sg_m_ff    <= sg_m_in;
      sg_base_ff <= sg_base_in;
      if (state_ff == S_SIG && sg_step_ff == 3'd2)
         h_ff[node_ff] <= h_in;
      if (state_ff == S_OMAC && ohid_ff == 2'(HidNodes - 1))
         s_ff[cls_ff] <= osum;
   end
endmodule
`default_nettype wire

/* tb/testbench.sv */
//------------------------------------------------------------------------------
// testbench
// Force gesture classifier check: random and directed force words driven
// through valid/ready, each response word compared with a built-in predictor
// of the window shift, phase flags and 6-4-3 perceptron argmax.
//------------------------------------------------------------------------------
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import fgc_pkg::*;

   typedef struct packed {
      logic [15:0] f0, f1, f2, f3, f4;
   } force_word_type;

   typedef struct packed {
      logic       point_valid;
      logic [2:0] point_index;
      logic       gesture_valid;
      logic [1:0] gesture;
   } track_word_type;

   localparam int IDX_THR0 = 0;
   localparam int IDX_BAD  = 7;
   localparam int WATCHDOG = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [15:0] req_force_ch0 = '0, req_force_ch1 = '0, req_force_ch2 = '0;
   logic [15:0] req_force_ch3 = '0, req_force_ch4 = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_point_valid;
   logic [2:0] rsp_point_index;
   logic rsp_gesture_valid;
   logic [1:0] rsp_gesture;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   always #2 clock = ~clock;

   force_gesture_mlp_classifier dut (.*);

   // predictor state
   logic [15:0] thr_m [FieldCh];
   logic [15:0] last_f [FieldCh];
   logic signed [16:0] win_m [FieldCh][WinLen];
   logic phase_m [FieldCh];
   gesture_type gest_m;

   force_word_type pending_q[$];
   track_word_type expect_q[$];
   int errors = 0, words_in = 0, words_out = 0, gestures_seen = 0, idle_cycles = 0;

   localparam int TAB [17] = '{32768, 40793, 47911, 53581, 57724, 60565, 62428,
      63615, 64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514};
   localparam int WIN_W [WinLen][HidNodes] = '{
      '{12408, -6561, -1484, -10099}, '{1689, -2068, -3138, -5588},
      '{7419, -643, -2043, 110}, '{21228, -5512, -11514, -7218},
      '{17922, -8046, -567, -6168}, '{13592, -6950, -510, -4235}};
   localparam int HID_W [HidNodes][ClassCnt] = '{
      '{12021, 4938, -17799}, '{18474, -28674, 3722},
      '{-9818, 1532, 22303}, '{-18106, 31813, -14282}};
   localparam int HID_B [HidNodes] = '{9467, -878, 4909, 2159};
   localparam int OUT_B [ClassCnt] = '{-3289, -9393, -2389};

   function automatic longint squash(longint z);
      longint a, v;
      int idx;
      a = (z < 0) ? -z : z;
      if (a > 131072) a = 131072;
      idx = int'(a >>> 13);
      if (idx >= 16) v = TAB[16];
      else v = TAB[idx] + (((TAB[idx+1] - TAB[idx]) * (a & 8191)) >>> 13);
      return (z < 0) ? 65536 - v : v;
   endfunction

   function automatic gesture_type classify_window(int c);
      longint h [HidNodes];
      longint s [ClassCnt];
      longint z;
      for (int j = 0; j < HidNodes; j++) begin
         z = longint'(HID_B[j]) * 16;
         for (int i = 0; i < WinLen; i++) z += longint'(WIN_W[i][j]) * win_m[c][i];
         h[j] = squash(z);
      end
      for (int k = 0; k < ClassCnt; k++) begin
         s[k] = longint'(OUT_B[k]) * 65536;
         for (int j = 0; j < HidNodes; j++) s[k] += longint'(HID_W[j][k]) * h[j];
      end
      if (s[0] > s[1] && s[0] > s[2]) return GEST_DOWN;
      if (s[2] > s[1] && s[2] > s[0]) return GEST_UP;
      if (s[1] > s[0] && s[1] > s[2]) return GEST_ROTATE;
      return GEST_NONE;
   endfunction

   function automatic track_word_type track_step(force_word_type w);
      logic [15:0] f [FieldCh];
      logic act [FieldCh];
      track_word_type r;
      f = '{w.f0, w.f1, w.f2, w.f3, w.f4};
      r = '0;
      for (int c = 0; c < FieldCh; c++) begin
         act[c] = f[c] > thr_m[c];
         if (act[c]) begin
            r.point_valid = 1'b1;
            r.point_index = 3'(c);
         end
      end
      if (r.point_valid) begin
         for (int c = 0; c < FieldCh; c++) begin
            for (int i = 0; i < WinLen - 1; i++) win_m[c][i] = win_m[c][i+1];
            win_m[c][WinLen-1] = {1'b0, f[c]} - {1'b0, last_f[c]};
            last_f[c] = f[c];
         end
         for (int c = 0; c < FieldCh; c++)
            if (act[c]) begin
               if (phase_m[c]) begin
                  gest_m = classify_window(c);
                  r.gesture_valid = 1'b1;
               end
               phase_m[c] = ~phase_m[c];
            end
      end
      r.gesture = gest_m;
      return r;
   endfunction

   task automatic report(string what, int got, int want);
      errors++;
      $display("mismatch word %0d %s: got %0d expected %0d", words_out, what, got, want);
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expect_q.push_back(track_step(pending_q.pop_front()));
            words_in++;
         end
         if (!req_valid || req_ready) begin
            if (pending_q.size() > 0 && ($urandom_range(0, 3) != 0 || pending_q.size() > 2000)) begin
               req_valid <= 1'b1;
               {req_force_ch0, req_force_ch1, req_force_ch2, req_force_ch3, req_force_ch4}
                  <= pending_q[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // hold-off pattern for the response side: mostly short gaps, a few long
   int rsp_hold = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expect_q.size() == 0) begin
               errors++;
               $display("unexpected response word");
            end else begin
               track_word_type e;
               e = expect_q.pop_front();
               if (rsp_point_valid !== e.point_valid)
                  report("point_valid", rsp_point_valid, e.point_valid);
               if (rsp_point_index !== e.point_index)
                  report("point_index", rsp_point_index, e.point_index);
               if (rsp_gesture_valid !== e.gesture_valid)
                  report("gesture_valid", rsp_gesture_valid, e.gesture_valid);
               if (rsp_gesture !== e.gesture) report("gesture", rsp_gesture, e.gesture);
               if (e.gesture_valid) gestures_seen++;
            end
            words_out++;
         end
         if (rsp_hold > 0) begin
            rsp_hold <= rsp_hold - 1;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(0, 9) == 0) begin
            rsp_hold <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 200)
                                                    : $urandom_range(1, 4);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG) begin
         $display("watchdog expired: %0d words pending", expect_q.size());
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic write_threshold(int idx, logic [15:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= 3'(idx);
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx < FieldCh) thr_m[idx] = val;
   endtask

   task automatic drain();
      while (pending_q.size() != 0 || req_valid || expect_q.size() != 0)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_force(int mode);
      case (mode)
         0: return 16'($urandom_range(0, 200));
         1: return 16'($urandom);
         2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: return 16'($urandom_range(0, 4000));
      endcase
   endfunction

   function automatic force_word_type rand_word(int mode);
      force_word_type w;
      w = {rand_force(mode), rand_force(mode), rand_force(mode), rand_force(mode),
           rand_force(mode)};
      return w;
   endfunction

   initial begin
      for (int c = 0; c < FieldCh; c++) begin
         last_f[c] = '0;
         phase_m[c] = 1'b0;
         for (int i = 0; i < WinLen; i++) win_m[c][i] = '0;
      end
      thr_m = '{16'd8, 16'd32, 16'd48, 16'd80, 16'd80};
      gest_m = GEST_NONE;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      repeat (60) @(posedge clock);   // memory clearing pass

      // directed: quiet, single channels, full-scale swings, all active
      pending_q.push_back('0);
      for (int c = 0; c < FieldCh; c++) begin
         force_word_type w;
         w = '0;
         w[16*(4-c) +: 16] = 16'hFFFF;
         pending_q.push_back(w);
         pending_q.push_back(w);
      end
      pending_q.push_back({5{16'hFFFF}});
      pending_q.push_back({5{16'h0000}});
      pending_q.push_back({5{16'hFFFF}});
      pending_q.push_back({5{16'h0001}});
      pending_q.push_back({5{16'hFFFF}});
      pending_q.push_back({5{16'hAAAA}});
      pending_q.push_back({5{16'h5555}});
      pending_q.push_back({16'd8, 16'd32, 16'd48, 16'd80, 16'd80});   // at threshold
      pending_q.push_back({16'd9, 16'd33, 16'd49, 16'd81, 16'd81});   // just above
      drain();

      // several threshold settings, extremes included; bad index ignored
      for (int phase = 0; phase < 4; phase++) begin
         for (int c = 0; c < FieldCh; c++)
            case (phase)
               0: write_threshold(IDX_THR0 + c, 16'hFFFF);
               1: write_threshold(IDX_THR0 + c, 16'h0000);
               2: write_threshold(IDX_THR0 + c, 16'($urandom_range(0, 300)));
               default: write_threshold(IDX_THR0 + c, 16'($urandom));
            endcase
         write_threshold(IDX_BAD, 16'($urandom));
         for (int n = 0; n < 300; n++) begin
            // mostly press gestures: ramps with random content, rest noise
            if ($urandom_range(0, 3) != 0) begin
               int base;
               base = $urandom_range(0, 3000);
               for (int k = 0; k < 6; k++) begin
                  force_word_type w;
                  w = rand_word(0);
                  w[16*$urandom_range(0, 4) +: 16] = 16'(base + k * $urandom_range(0, 600));
                  pending_q.push_back(w);
               end
               n += 5;
            end else begin
               pending_q.push_back(rand_word($urandom_range(0, 3)));
            end
         end
         drain();
      end
      $display("covered %0d force words, %0d classified ticks, 5 threshold settings",
               words_in, gestures_seen);
      if (errors == 0 && expect_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
`default_nettype wire

/* filelist.f */
src/fgc_pkg.sv
src/fgc_mlp.sv
src/force_gesture_mlp_classifier.sv
tb/testbench.sv
